// ===== rtl/xcfd_pkg.sv =====
`timescale 1ns / 1ps

package xcfd_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;
  localparam logic [1:0] KIND_TRUNC   = 2'd3;

  // sync byte after reset
  localparam logic [7:0] SYNC_RESET = 8'hA9;

  // register index of sync_value
  localparam logic REG_SYNC_VALUE = 1'b0;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
  } out_word_t;

  // one parsed byte: an optional first result and an optional truncation result
  typedef struct packed {
    logic       first_valid;
    logic [1:0] first_kind;
    logic       trunc_valid;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
  } entry_t;

endpackage

// ===== rtl/xcfd_front.sv =====
`timescale 1ns / 1ps

module xcfd_front
  import xcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] sync_value,
  input  logic       take,
  input  in_word_t   word,
  output logic       push,
  output entry_t     entry
);

  localparam logic [2:0] PH_SYNC    = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAY     = 3'd3;
  localparam logic [2:0] PH_SUM     = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0] phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;

  always_comb begin
    logic [7:0] b;
    logic [2:0] ph;
    b = word.rx_byte;
    ph = phase;
    running_xor_next = running_xor;
    frame_command_next = frame_command;
    declared_length_next = declared_length;
    bytes_seen_next = bytes_seen;
    entry.first_valid = 1'b0;
    entry.first_kind = KIND_PAYLOAD;
    entry.payload_byte = 8'd0;
    entry.payload_index = 8'd0;
    case (phase)
      PH_CMD: begin
        running_xor_next = running_xor ^ b;
        frame_command_next = b;
        ph = PH_LEN;
      end
      PH_LEN: begin
        running_xor_next = running_xor ^ b;
        declared_length_next = b;
        bytes_seen_next = 8'd0;
        ph = (b == 8'd0) ? PH_SUM : PH_PAY;
      end
      PH_PAY: begin
        running_xor_next = running_xor ^ b;
        entry.first_valid = 1'b1;
        entry.first_kind = KIND_PAYLOAD;
        entry.payload_byte = b;
        entry.payload_index = bytes_seen;
        bytes_seen_next = bytes_seen + 8'd1;
        if (bytes_seen + 8'd1 == declared_length) ph = PH_SUM;
      end
      PH_SUM: begin
        entry.first_valid = 1'b1;
        entry.first_kind = (b == running_xor) ? KIND_GOOD : KIND_BAD;
        ph = PH_SYNC;
      end
      PH_DISCARD: begin
        ph = PH_DISCARD;
      end
      default: begin
        if (b == sync_value) begin
          running_xor_next = b;
          frame_command_next = 8'd0;
          declared_length_next = 8'd0;
          bytes_seen_next = 8'd0;
          ph = PH_CMD;
        end else begin
          ph = PH_DISCARD;
        end
      end
    endcase
    entry.trunc_valid = word.burst_end && (ph != PH_SYNC) && (ph != PH_DISCARD);
    phase_next = word.burst_end ? PH_SYNC : ph;
    entry.command = frame_command_next;
    entry.frame_length = declared_length_next;
  end

  assign push = take && (entry.first_valid || entry.trunc_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      running_xor <= 8'd0;
      frame_command <= 8'd0;
      declared_length <= 8'd0;
      bytes_seen <= 8'd0;
    end else if (take) begin
      phase <= phase_next;
      running_xor <= running_xor_next;
      frame_command <= frame_command_next;
      declared_length <= declared_length_next;
      bytes_seen <= bytes_seen_next;
    end
  end

endmodule

// ===== rtl/xcfd_queue.sv =====
`timescale 1ns / 1ps

module xcfd_queue
  import xcfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == FULL_COUNT);
  assign empty = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not follow a write");
`endif

endmodule

// ===== rtl/xcfd_back.sv =====
`timescale 1ns / 1ps

module xcfd_back
  import xcfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  entry_t    head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  entry_t cur;
  logic   cur_valid;
  logic   second;
  logic   out_take;
  logic   finishing;
  logic   show_trunc;

  // trunc result goes out on its own, or after the first result
  assign show_trunc = !cur.first_valid || second;
  assign out_take = cur_valid && !out_stall;
  assign finishing = out_take && !(cur.first_valid && cur.trunc_valid && !second);
  assign pop = (!cur_valid || finishing) && !empty;

  assign out_valid = cur_valid;
  always_comb begin
    out_word.command = cur.command;
    out_word.frame_length = cur.frame_length;
    if (show_trunc) begin
      out_word.kind = KIND_TRUNC;
      out_word.payload_byte = 8'd0;
      out_word.payload_index = 8'd0;
    end else begin
      out_word.kind = cur.first_kind;
      out_word.payload_byte = cur.payload_byte;
      out_word.payload_index = cur.payload_index;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      second <= 1'b0;
    end else if (finishing) begin
      cur_valid <= 1'b0;
      second <= 1'b0;
    end else if (out_take) begin
      second <= 1'b1;
    end
  end

endmodule

// ===== rtl/xor_checked_frame_deframer.sv =====
`timescale 1ns / 1ps

// frame deframer with xor check for a received serial byte stream. each input word
// carries one byte and a burst_end flag for the last byte of a receive burst. a frame
// is sync byte, command, payload length, payload bytes, then the xor of all bytes before
// it. every payload byte comes out as a result word as it arrives, the checksum byte
// gives a good or mismatch word, and a burst that ends inside a frame gives a truncated
// word (after the payload word of that byte, if any). a byte that should be sync but is
// not drops the rest of its burst. the parser takes one byte per clock unless the
// queue is full; the output side gives one result word per clock unless out_stall
// is high; the entry queue absorbs the extra word of a payload-plus-truncation byte.
// a result is registered in the queue, then in the output register. sync_value is at
// byte address 0 of the apb port, written only while idle by the user (not enforced).

module xor_checked_frame_deframer
  import xcfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] sync_value;
  logic       in_take;
  logic       push;
  entry_t     push_data;
  logic       full;
  logic       pop;
  entry_t     head;
  logic       empty;

  // config register, single entry at address 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SYNC_VALUE) ? {24'd0, sync_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SYNC_VALUE)) begin
      sync_value <= pwdata[7:0];
    end
  end

  // parser stalls only when the queue has no room
  assign in_stall = full;
  assign in_take = in_valid && !in_stall;

  xcfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sync_value (sync_value),
    .take       (in_take),
    .word       (in_word),
    .push       (push),
    .entry      (push_data)
  );

  xcfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  xcfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
